### rtl/trrs_pkg.sv
// -----------------------------------------------------------------------------
// trrs_pkg: shared types and codes for the round-robin thread scheduler.
// Holds the command and result beat structs and the state encodings.
// -----------------------------------------------------------------------------
package trrs_pkg;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] target_id;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] new_id;
    logic [15:0] running_id;
    logic        switched;
    logic [31:0] switch_count;
  } res_t;

  // Command kinds.
  localparam logic [2:0] KindCreate   = 3'd0;
  localparam logic [2:0] KindUnpark   = 3'd1;
  localparam logic [2:0] KindPark     = 3'd2;
  localparam logic [2:0] KindExit     = 3'd3;
  localparam logic [2:0] KindYield    = 3'd4;
  localparam logic [2:0] KindSuspend  = 3'd5;
  localparam logic [2:0] KindContinue = 3'd6;
  localparam logic [2:0] KindWakeup   = 3'd7;

  // Result status codes.
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StNotSleep = 3'd2;
  localparam logic [2:0] StNoRun    = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  // Run states.
  localparam logic [1:0] RsZombie = 2'd0;
  localparam logic [1:0] RsRun    = 2'd1;
  localparam logic [1:0] RsSleep  = 2'd2;
  localparam logic [1:0] RsSusp   = 2'd3;

  // CPU marks.
  localparam logic [1:0] CpuNone   = 2'd0;
  localparam logic [1:0] CpuOn     = 2'd1;
  localparam logic [1:0] CpuExited = 2'd2;

  localparam logic [15:0] FirstId = 16'd2;

endpackage

### rtl/trrs_ram.sv
// -----------------------------------------------------------------------------
// trrs_ram: generic single-port-write, single-port-read synchronous RAM.
// The read data is registered and appears in the cycle after the address.
// -----------------------------------------------------------------------------
module trrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/thread_round_robin_scheduler_unit.sv
// -----------------------------------------------------------------------------
// thread_round_robin_scheduler_unit: cooperative round-robin thread scheduler.
// Slot records and the run-order list live in two synchronous RAMs; a
// sequencer walks the list one entry per step to look up ids and pick the
// next runnable thread, then rotates the chosen slot to the tail.
//
//   channel   signals                 direction  meaning
//   command   start_i, busy_o, cmd_i  in         one command beat
//   result    done_o, res_o           out        one result beat per command
//
// A create is a short command; the longest are a park or an exit over a full
// list: the list walk reads each entry's order word, then its slot, then
// compares it, and a list removal shifts entries one at a time through the
// order RAM, reading each entry and then writing it one place down.
// After reset a clearing pass writes every entry of the slot RAM;
// busy_o is high during it. A result beat is shown on done_o for one cycle
// and cannot be stalled; busy_o stays high until it has been shown.
// -----------------------------------------------------------------------------
module thread_round_robin_scheduler_unit #(
  parameter int MaxThreads = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  trrs_pkg::cmd_t cmd_i,
  output logic           busy_o,
  output logic           done_o,
  output trrs_pkg::res_t res_o
);
  import trrs_pkg::*;

  localparam int Aw = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int Lw = $clog2(MaxThreads + 1);
  localparam int RecW = 16 + 2 + 2 + 32;
  localparam logic [Lw-1:0] LenMax = Lw'(MaxThreads);

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  rs;
    logic [1:0]  cpu;
    logic [31:0] sw;
  } rec_t;

  // Sequencer states.
  localparam logic [4:0] SClr     = 5'd0;
  localparam logic [4:0] SIdle    = 5'd1;
  localparam logic [4:0] SFindRd  = 5'd2;  // read order entry i
  localparam logic [4:0] SFindSl  = 5'd3;  // order data -> read slot
  localparam logic [4:0] SFindChk = 5'd4;  // slot data -> compare
  localparam logic [4:0] SModRd   = 5'd5;  // read found slot for modify
  localparam logic [4:0] SModWr   = 5'd6;
  localparam logic [4:0] SCurRd   = 5'd7;  // read current slot
  localparam logic [4:0] SCurWr   = 5'd8;
  localparam logic [4:0] SRemRd   = 5'd9;  // shift list: read i+1
  localparam logic [4:0] SRemWr   = 5'd10; // write to i
  localparam logic [4:0] SFreeRd  = 5'd11; // free slot scan
  localparam logic [4:0] SFreeChk = 5'd12;
  localparam logic [4:0] SCreate  = 5'd13;
  localparam logic [4:0] SRunWait = 5'd14; // prev slot read for mark
  localparam logic [4:0] SPrevWr  = 5'd15;
  localparam logic [4:0] SNewRd   = 5'd16;
  localparam logic [4:0] SNewWr   = 5'd17;
  localparam logic [4:0] SOutRd   = 5'd18;
  localparam logic [4:0] SOut     = 5'd19;
  localparam logic [4:0] SDone    = 5'd20;

  // Walk purposes.
  localparam logic [1:0] PLookup = 2'd0;
  localparam logic [1:0] PSched  = 2'd1;
  localparam logic [1:0] PPos    = 2'd2;

  logic [4:0] st_q, st_d;
  logic [1:0] pur_q, pur_d;
  logic [2:0] kind_q, kind_d;
  logic [15:0] tgt_q, tgt_d;
  logic [Lw-1:0] idx_q, idx_d;
  logic [Lw-1:0] len_q, len_d;
  logic [Aw-1:0] cur_q, cur_d;
  logic [15:0] nid_q, nid_d;
  logic [Aw-1:0] hit_q, hit_d;   // slot found by the walk
  logic [2:0] status_q, status_d;
  logic [15:0] newid_q, newid_d;
  logic sw_q, sw_d;
  logic after_q, after_d; // removal: 0 exit path, 1 reschedule rotate
  logic [Aw:0] clr_q, clr_d;
  logic [MaxThreads-1:0] inlist_q, inlist_d;
  res_t res_q, res_d;
  logic done_q, done_d;

  // RAM ports.
  logic          s_we, o_we;
  logic [Aw-1:0] s_wa, s_ra, o_wa, o_ra;
  rec_t          s_wd, s_rd;
  logic [Aw-1:0] o_wd, o_rd;
  logic [RecW-1:0] s_rd_raw;

  trrs_ram #(.Width(RecW), .Depth(MaxThreads)) u_slot_ram (
    .clk_i(clk_i), .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .raddr_i(s_ra), .rdata_o(s_rd_raw)
  );
  assign s_rd = rec_t'(s_rd_raw);

  trrs_ram #(.Width(Aw), .Depth(MaxThreads)) u_order_ram (
    .clk_i(clk_i), .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd),
    .raddr_i(o_ra), .rdata_o(o_rd)
  );

  assign busy_o = (st_q != SIdle);
  assign done_o = done_q;
  assign res_o  = res_q;

  // Free-slot search over the in-list bitmap (lowest free, not current).
  logic          free_ok;
  logic [Aw-1:0] free_ix;
  always_comb begin
    free_ok = 1'b0;
    free_ix = '0;
    for (int f = MaxThreads - 1; f >= 0; f--) begin
      if (!inlist_q[f] && (Aw'(f) != cur_q)) begin
        free_ok = 1'b1;
        free_ix = Aw'(f);
      end
    end
  end

  // Main sequencer.
  always_comb begin
    st_d = st_q; pur_d = pur_q; kind_d = kind_q; tgt_d = tgt_q;
    idx_d = idx_q; len_d = len_q; cur_d = cur_q; nid_d = nid_q;
    hit_d = hit_q;
    status_d = status_q; newid_d = newid_q; sw_d = sw_q; after_d = after_q;
    clr_d = clr_q; inlist_d = inlist_q; res_d = res_q; done_d = 1'b0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    case (st_q)
      SClr: begin
        s_we = 1'b1;
        s_wa = clr_q[Aw-1:0];
        s_wd = (clr_q == '0) ? rec_t'{16'd1, RsRun, CpuOn, 32'd0}
                             : rec_t'{16'd0, RsZombie, CpuNone, 32'd0};
        o_we = (clr_q == '0);
        o_wa = '0;
        o_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == (Aw+1)'(MaxThreads - 1)) st_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          kind_d = cmd_i.kind; tgt_d = cmd_i.target_id;
          status_d = StOk; newid_d = '0; sw_d = 1'b0;
          idx_d = '0;
          case (cmd_i.kind)
            KindCreate: st_d = SCreate;
            KindYield: begin pur_d = PSched; st_d = SFindRd; end
            KindExit: begin pur_d = PPos; st_d = SCurRd; end
            KindPark: begin
              if (cmd_i.target_id != '0) begin
                pur_d = PLookup; st_d = SFindRd;
              end else begin
                st_d = SCurRd;
              end
            end
            default: begin pur_d = PLookup; st_d = SFindRd; end
          endcase
        end
      end
      // List walk: one entry per step.
      SFindRd: begin
        if (idx_q >= len_q) begin
          // End of list.
          if (pur_q == PLookup) begin
            if (kind_q == KindPark) st_d = SCurRd;
            else begin status_d = StNotFound; st_d = SOutRd; end
          end else if (pur_q == PSched) begin
            status_d = StNoRun; st_d = SOutRd;
          end else begin
            st_d = SOutRd; pur_d = PSched; idx_d = '0; st_d = SFindRd;
          end
        end else begin
          o_ra = idx_q[Aw-1:0];
          st_d = SFindSl;
        end
      end
      SFindSl: begin
        s_ra = o_rd;
        hit_d = o_rd;
        st_d = SFindChk;
      end
      SFindChk: begin
        logic m;
        m = 1'b0;
        case (pur_q)
          PLookup: m = (s_rd.id == tgt_q);
          PSched:  m = (s_rd.rs == RsRun);
          default: m = (hit_q == cur_q);
        endcase
        if (m) begin
          if (pur_q == PLookup) begin
            s_ra = hit_q; st_d = SModRd;
          end else if (pur_q == PSched) begin
            after_d = 1'b1; idx_d = idx_q; st_d = SRemRd;
          end else begin
            after_d = 1'b0; idx_d = idx_q; st_d = SRemRd;
            inlist_d[hit_q] = 1'b0;
          end
        end else begin
          idx_d = idx_q + 1'b1; st_d = SFindRd;
        end
      end
      // Modify the found slot's run state.
      SModRd: begin
        s_ra = hit_q; st_d = SModWr;
      end
      SModWr: begin
        s_we = 1'b1; s_wa = hit_q; s_wd = s_rd;
        case (kind_q)
          KindSuspend: s_wd.rs = RsSusp;
          KindWakeup: begin
            if (s_rd.rs == RsSleep) s_wd.rs = RsRun;
            else begin s_we = 1'b0; status_d = StNotSleep; end
          end
          default: s_wd.rs = RsRun;
        endcase
        st_d = (kind_q == KindPark) ? SCurRd : SOutRd;
      end
      // Current slot update for park and exit.
      SCurRd: begin
        s_ra = cur_q; st_d = SCurWr;
      end
      SCurWr: begin
        s_we = 1'b1; s_wa = cur_q; s_wd = s_rd;
        if (kind_q == KindPark) begin
          s_wd.rs = RsSleep;
          pur_d = PSched; idx_d = '0; st_d = SFindRd;
        end else begin
          s_wd.rs = RsZombie; s_wd.cpu = CpuExited;
          pur_d = PPos; idx_d = '0; st_d = SFindRd;
        end
      end
      // Shift list entries after idx down by one.
      SRemRd: begin
        if (idx_q + 1'b1 >= len_q) begin
          len_d = len_q - 1'b1;
          if (after_q) begin
            o_we = 1'b1; o_wa = Aw'(len_q - 1'b1); o_wd = hit_q;
            len_d = len_q;
            s_ra = cur_q; st_d = SRunWait;
          end else begin
            pur_d = PSched; idx_d = '0; st_d = SFindRd;
          end
        end else begin
          o_ra = Aw'(idx_q + 1'b1); st_d = SRemWr;
        end
      end
      SRemWr: begin
        o_we = 1'b1; o_wa = idx_q[Aw-1:0]; o_wd = o_rd;
        idx_d = idx_q + 1'b1; st_d = SRemRd;
      end
      // Previous slot: clear its mark unless zombie.
      SRunWait: begin
        s_ra = cur_q; st_d = SPrevWr;
      end
      SPrevWr: begin
        if (s_rd.rs != RsZombie) begin
          s_we = 1'b1; s_wa = cur_q; s_wd = s_rd; s_wd.cpu = CpuNone;
        end
        st_d = SNewRd;
      end
      SNewRd: begin
        s_ra = hit_q; st_d = SNewWr;
      end
      SNewWr: begin
        s_we = 1'b1; s_wa = hit_q; s_wd = s_rd;
        s_wd.cpu = CpuOn; s_wd.sw = s_rd.sw + 32'd1;
        cur_d = hit_q; sw_d = 1'b1; st_d = SOutRd;
      end
      SCreate: begin
        if (!free_ok || len_q >= LenMax) begin
          status_d = StFull; st_d = SOutRd;
        end else begin
          newid_d = nid_q;
          nid_d = (nid_q == 16'hFFFF) ? FirstId : nid_q + 16'd1;
          s_we = 1'b1; s_wa = free_ix;
          s_wd = rec_t'{nid_q, RsRun, CpuNone, 32'd0};
          o_we = 1'b1; o_wa = len_q[Aw-1:0]; o_wd = free_ix;
          len_d = len_q + 1'b1; inlist_d[free_ix] = 1'b1;
          st_d = SOutRd;
        end
      end
      SOutRd: begin
        s_ra = cur_q; st_d = SOut;
      end
      SOut: begin
        res_d.status = status_q; res_d.new_id = newid_q;
        res_d.running_id = s_rd.id; res_d.switched = sw_q;
        res_d.switch_count = s_rd.sw;
        done_d = 1'b1; st_d = SDone;
      end
      SDone: begin
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; pur_q <= PLookup; kind_q <= '0; tgt_q <= '0;
      idx_q <= '0; len_q <= Lw'(1); cur_q <= '0; nid_q <= FirstId;
      hit_q <= '0;
      status_q <= '0; newid_q <= '0; sw_q <= 1'b0; after_q <= 1'b0;
      clr_q <= '0; inlist_q <= MaxThreads'(1); done_q <= 1'b0;
    end else begin
      st_q <= st_d; pur_q <= pur_d; kind_q <= kind_d; tgt_q <= tgt_d;
      idx_q <= idx_d; len_q <= len_d; cur_q <= cur_d; nid_q <= nid_d;
      hit_q <= hit_d;
      status_q <= status_d; newid_q <= newid_d;
      sw_q <= sw_d; after_q <= after_d; clr_q <= clr_d;
      inlist_q <= inlist_d; done_q <= done_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
